### hdl/psi_pkg.sv
// ----------------------------------------------------------------------------
// psi_pkg: shared types and constants of the padding segment inserter
// Field widths, configuration register indexes, the emit selector and the
// command/status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package psi_pkg;

    // Default bound on the contour length
    localparam int MAX_SEGMENTS_DEF = 256;

    // Field widths
    localparam int VERB_W     = 3;
    localparam int PCOUNT_W   = 3;
    localparam int COORD_W    = 32;
    localparam int NUM_COORDS = 8;
    localparam int PAD_W      = 6;
    localparam int SEGT_W     = 9;
    localparam int REPS_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    typedef logic [VERB_W-1:0]     verb_t;
    typedef logic [PCOUNT_W-1:0]   pcount_t;
    typedef logic [COORD_W-1:0]    coord_t;
    typedef logic [PAD_W-1:0]      pad_t;
    typedef logic [SEGT_W-1:0]     segt_t;
    typedef logic [REPS_W-1:0]     reps_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // Configuration register indexes
    localparam cfg_idx_t CFG_PAD_COUNT     = 2'd0;
    localparam cfg_idx_t CFG_SEGMENT_TOTAL = 2'd1;

    // Which kind of word the datapath builds
    typedef enum logic [1:0] {
        EMIT_ORIG      = 2'd0,
        EMIT_PAD_FIRST = 2'd1,
        EMIT_PAD_TRAIL = 2'd2
    } emit_kind_t;

    // Controller to datapath
    typedef struct packed {
        logic       accept;
        logic       div_start;
        logic       div_latch;
        logic       cnt_load;
        logic       cnt_dec;
        logic       err_update;
        logic       seen_advance;
        logic       emit;
        emit_kind_t emit_kind;
        logic       run_end;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic seen_zero;
        logic div_done;
        logic cnt_zero;
        logic cnt_one;
        logic err_pos;
        logic is_last;
        logic reps_zero;
        logic out_free;
    } sts_t;

endpackage

### hdl/psi_in_if.sv
// ----------------------------------------------------------------------------
// psi_in_if: segment input channel
// Valid/ready channel carrying one contour segment per word.
// ----------------------------------------------------------------------------
interface psi_in_if;

    logic             valid;
    logic             ready;
    psi_pkg::verb_t   seg_verb;
    psi_pkg::pcount_t point_count;
    psi_pkg::coord_t  p0_x;
    psi_pkg::coord_t  p0_y;
    psi_pkg::coord_t  p1_x;
    psi_pkg::coord_t  p1_y;
    psi_pkg::coord_t  p2_x;
    psi_pkg::coord_t  p2_y;
    psi_pkg::coord_t  p3_x;
    psi_pkg::coord_t  p3_y;

    modport source (
        output valid, seg_verb, point_count, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y,
               p3_x, p3_y,
        input  ready
    );

    modport sink (
        input  valid, seg_verb, point_count, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y,
               p3_x, p3_y,
        output ready
    );

endinterface

### hdl/psi_out_if.sv
// ----------------------------------------------------------------------------
// psi_out_if: segment output channel
// Valid/ready channel carrying one emitted segment per word.
// ----------------------------------------------------------------------------
interface psi_out_if;

    logic            valid;
    logic            ready;
    psi_pkg::verb_t  out_verb;
    psi_pkg::coord_t q0_x;
    psi_pkg::coord_t q0_y;
    psi_pkg::coord_t q1_x;
    psi_pkg::coord_t q1_y;
    psi_pkg::coord_t q2_x;
    psi_pkg::coord_t q2_y;
    psi_pkg::coord_t q3_x;
    psi_pkg::coord_t q3_y;
    logic            is_padding;
    logic            run_end;

    modport source (
        output valid, out_verb, q0_x, q0_y, q1_x, q1_y, q2_x, q2_y, q3_x, q3_y,
               is_padding, run_end,
        input  ready
    );

    modport sink (
        input  valid, out_verb, q0_x, q0_y, q1_x, q1_y, q2_x, q2_y, q3_x, q3_y,
               is_padding, run_end,
        output ready
    );

endinterface

### hdl/psi_cfg_if.sv
// ----------------------------------------------------------------------------
// psi_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface psi_cfg_if;

    logic                valid;
    logic                ready;
    psi_pkg::cfg_idx_t   index;
    psi_pkg::cfg_data_t  data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );

endinterface

### hdl/psi_div.sv
// ----------------------------------------------------------------------------
// psi_div: restoring divider for the padding split
// Divides the 6-bit padding count by the segment count plus one, one
// quotient bit per cycle; done pulses once quotient and remainder are ready.
// ----------------------------------------------------------------------------
module psi_div #(
    parameter int DIV_W = 9
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  psi_pkg::pad_t      dividend,
    input  logic [DIV_W-1:0]   divisor,
    output logic               done,
    output psi_pkg::pad_t      quot,
    output psi_pkg::pad_t      rem
);

    localparam int PW    = psi_pkg::PAD_W;
    localparam int TW    = PW + 1;
    localparam int CW    = (TW > DIV_W) ? TW : DIV_W;
    localparam int STEPW = $clog2(PW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [STEPW-1:0] step_reg, step_next;
    psi_pkg::pad_t    quot_reg, quot_next;
    psi_pkg::pad_t    rem_reg, rem_next;

    logic [TW-1:0]    trial;
    logic [CW-1:0]    trial_w;
    logic [CW-1:0]    div_w;
    logic             ge;

    // Trial subtract of the shifted partial remainder
    always_comb
    begin
        trial   = {rem_reg, quot_reg[PW-1]};
        trial_w = CW'(trial);
        div_w   = CW'(divisor);
        ge      = (trial_w >= div_w);
    end

    // Advance one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEPW'(PW);
            quot_next = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[PW-2:0], ge};
            rem_next  = ge ? PW'(trial_w - div_w) : trial[PW-1:0];
            step_next = step_reg - STEPW'(1);
            if (step_reg == STEPW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

### hdl/psi_dp.sv
// ----------------------------------------------------------------------------
// psi_dp: datapath of the padding segment inserter
// Holds the configuration, the current segment, the contour state
// (verb, quotient, remainder, error term, segment count), the repeat
// counter and the output word register.
// ----------------------------------------------------------------------------
module psi_dp #(
    parameter int MAX_SEGMENTS = psi_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration writes
    input  logic                 cfg_we,
    input  psi_pkg::cfg_idx_t    cfg_index,
    input  psi_pkg::cfg_data_t   cfg_data,
    // input word fields
    input  psi_pkg::verb_t       in_verb,
    input  psi_pkg::pcount_t     in_pcount,
    input  psi_pkg::coord_t      in_pts [psi_pkg::NUM_COORDS],
    // output word
    input  logic                 out_ready,
    output logic                 out_valid,
    output psi_pkg::verb_t       out_verb,
    output psi_pkg::coord_t      out_pts [psi_pkg::NUM_COORDS],
    output logic                 out_pad,
    output logic                 out_end,
    // controller link
    input  psi_pkg::cmd_t        cmd,
    output psi_pkg::sts_t        sts
);

    localparam int NC    = psi_pkg::NUM_COORDS;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int DIV_W = $clog2(MAX_SEGMENTS + 2);
    // Error term may climb by twice the split remainder on every segment of a
    // contour that outlives a lowered segment count
    localparam int ERR_W = CNT_W + psi_pkg::PAD_W + 2;

    // Configuration registers
    psi_pkg::pad_t  pad_count_reg;
    psi_pkg::segt_t seg_total_reg;

    // Current segment
    psi_pkg::verb_t   item_verb_reg;
    psi_pkg::pcount_t item_pcount_reg;
    psi_pkg::coord_t  item_pts_reg [NC];

    // Contour state
    psi_pkg::verb_t        base_verb_reg;
    psi_pkg::reps_t        reps_reg;
    psi_pkg::pad_t         extra_reg;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic [CNT_W-1:0]      seen_reg, seen_next;
    psi_pkg::reps_t        cnt_reg, cnt_next;

    // Output word
    logic            out_valid_reg;
    psi_pkg::verb_t  out_verb_reg;
    psi_pkg::coord_t out_pts_reg [NC];
    logic            out_pad_reg;
    logic            out_end_reg;

    logic [CNT_W-1:0]        total;
    logic [DIV_W-1:0]        divisor;
    logic                    div_done;
    psi_pkg::pad_t           div_quot;
    psi_pkg::pad_t           div_rem;
    logic                    err_pos;
    logic                    is_last;
    logic signed [ERR_W-1:0] extra_s;
    logic signed [ERR_W-1:0] total_s;
    logic signed [ERR_W-1:0] rem_s;
    logic signed [ERR_W-1:0] err_init;
    logic [1:0]              trail_idx;
    psi_pkg::verb_t          emit_verb;
    psi_pkg::coord_t         emit_pts [NC];
    logic                    emit_pad;

    // Clamp the segment count to 1..MAX_SEGMENTS
    always_comb
    begin
        if (seg_total_reg == '0)
            total = CNT_W'(1);
        else if (32'(seg_total_reg) > 32'(MAX_SEGMENTS))
            total = CNT_W'(MAX_SEGMENTS);
        else
            total = CNT_W'(seg_total_reg);
    end

    assign divisor = DIV_W'(total) + DIV_W'(1);

    // Split the padding count at the contour's first segment
    psi_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (pad_count_reg),
        .divisor  (divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // Bresenham error term arithmetic
    always_comb
    begin
        extra_s  = $signed(ERR_W'(extra_reg));
        total_s  = $signed(ERR_W'(total));
        rem_s    = $signed(ERR_W'(div_rem));
        err_init = (rem_s <<< 1) - total_s;
        err_pos  = (err_reg > $signed(ERR_W'(0)));
        err_next = err_reg;
        if (cmd.div_latch)
            err_next = err_init;
        else if (cmd.err_update)
        begin
            if (err_pos)
                err_next = err_reg + ((extra_s - total_s) <<< 1);
            else
                err_next = err_reg + (extra_s <<< 1);
        end
    end

    // Contour position
    always_comb
    begin
        is_last   = (({1'b0, seen_reg} + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(total));
        seen_next = seen_reg;
        if (cmd.seen_advance)
            seen_next = is_last ? '0 : seen_reg + CNT_W'(1);
    end

    // Repeat counter
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.div_latch)
            cnt_next = psi_pkg::reps_t'(div_quot);
        else if (cmd.cnt_load)
            cnt_next = reps_reg;
        else if (cmd.cnt_dec)
            cnt_next = cnt_reg - psi_pkg::reps_t'(1);
    end

    // Pick the trailing point from the point count
    always_comb
    begin
        case (item_pcount_reg)
            3'd0:    trail_idx = 2'd0;
            3'd1:    trail_idx = 2'd0;
            3'd2:    trail_idx = 2'd1;
            3'd3:    trail_idx = 2'd2;
            3'd4:    trail_idx = 2'd3;
            default: trail_idx = 2'd3;
        endcase
    end

    // Build the word to emit
    always_comb
    begin
        emit_verb = item_verb_reg;
        emit_pad  = 1'b0;
        for (int i = 0; i < NC; i++)
            emit_pts[i] = item_pts_reg[i];
        case (cmd.emit_kind)
            psi_pkg::EMIT_ORIG:
            begin
                emit_verb = item_verb_reg;
                emit_pad  = 1'b0;
            end
            psi_pkg::EMIT_PAD_FIRST:
            begin
                emit_verb = base_verb_reg;
                emit_pad  = 1'b1;
                for (int i = 0; i < NC / 2; i++)
                begin
                    emit_pts[2*i]   = item_pts_reg[0];
                    emit_pts[2*i+1] = item_pts_reg[1];
                end
            end
            psi_pkg::EMIT_PAD_TRAIL:
            begin
                emit_verb = base_verb_reg;
                emit_pad  = 1'b1;
                for (int i = 0; i < NC / 2; i++)
                begin
                    emit_pts[2*i]   = item_pts_reg[{trail_idx, 1'b0}];
                    emit_pts[2*i+1] = item_pts_reg[{trail_idx, 1'b1}];
                end
            end
            default:
            begin
                emit_verb = item_verb_reg;
                emit_pad  = 1'b0;
            end
        endcase
    end

    // Control and contour state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_count_reg <= '0;
            seg_total_reg <= psi_pkg::segt_t'(1);
            base_verb_reg <= '0;
            reps_reg      <= '0;
            extra_reg     <= '0;
            err_reg       <= '0;
            seen_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // take register writes
            if (cfg_we)
            begin
                if (cfg_index == psi_pkg::CFG_PAD_COUNT)
                    pad_count_reg <= cfg_data[psi_pkg::PAD_W-1:0];
                else if (cfg_index == psi_pkg::CFG_SEGMENT_TOTAL)
                    seg_total_reg <= cfg_data[psi_pkg::SEGT_W-1:0];
            end
            // latch the contour split
            if (cmd.div_latch)
            begin
                base_verb_reg <= item_verb_reg;
                reps_reg      <= psi_pkg::reps_t'(div_quot);
                extra_reg     <= div_rem;
            end
            err_reg  <= err_next;
            seen_reg <= seen_next;
            cnt_reg  <= cnt_next;
            // hold the output word until taken
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_verb_reg   <= in_verb;
            item_pcount_reg <= in_pcount;
            for (int i = 0; i < NC; i++)
                item_pts_reg[i] <= in_pts[i];
        end
        if (cmd.emit)
        begin
            out_verb_reg <= emit_verb;
            out_pad_reg  <= emit_pad;
            out_end_reg  <= cmd.run_end;
            for (int i = 0; i < NC; i++)
                out_pts_reg[i] <= emit_pts[i];
        end
    end

    // Status to the controller
    always_comb
    begin
        sts.seen_zero = (seen_reg == '0);
        sts.div_done  = div_done;
        sts.cnt_zero  = (cnt_reg == '0);
        sts.cnt_one   = (cnt_reg == psi_pkg::reps_t'(1));
        sts.err_pos   = err_pos;
        sts.is_last   = is_last;
        sts.reps_zero = (reps_reg == '0);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_verb  = out_verb_reg;
    assign out_pad   = out_pad_reg;
    assign out_end   = out_end_reg;
    always_comb
    begin
        for (int i = 0; i < NC; i++)
            out_pts[i] = out_pts_reg[i];
    end

endmodule

### hdl/psi_ctrl.sv
// ----------------------------------------------------------------------------
// psi_ctrl: sequencing controller of the padding segment inserter
// Walks each segment through split (contour's first only), leading padding,
// Bresenham extra copy, the original word and trailing padding (last only).
// ----------------------------------------------------------------------------
module psi_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  psi_pkg::sts_t sts,
    output psi_pkg::cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_PRE   = 6'b000100,
        ST_EXTRA = 6'b001000,
        ST_ORIG  = 6'b010000,
        ST_POST  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.emit_kind = psi_pkg::EMIT_ORIG;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.seen_zero)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                    else
                    begin
                        cmd.cnt_load = 1'b1;
                        state_next   = ST_PRE;
                    end
                end
            end
            ST_DIV:
            begin
                // latch quotient, remainder, error term and verb
                if (sts.div_done)
                begin
                    cmd.div_latch = 1'b1;
                    state_next    = ST_PRE;
                end
            end
            ST_PRE:
            begin
                if (sts.cnt_zero)
                    state_next = ST_EXTRA;
                else if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = psi_pkg::EMIT_PAD_FIRST;
                    cmd.cnt_dec   = 1'b1;
                end
            end
            ST_EXTRA:
            begin
                // extra copy when the error term is positive
                if (sts.err_pos)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit       = 1'b1;
                        cmd.emit_kind  = psi_pkg::EMIT_PAD_FIRST;
                        cmd.err_update = 1'b1;
                        state_next     = ST_ORIG;
                    end
                end
                else
                begin
                    cmd.err_update = 1'b1;
                    state_next     = ST_ORIG;
                end
            end
            ST_ORIG:
            begin
                if (sts.out_free)
                begin
                    cmd.emit         = 1'b1;
                    cmd.emit_kind    = psi_pkg::EMIT_ORIG;
                    cmd.seen_advance = 1'b1;
                    if (sts.is_last && !sts.reps_zero)
                    begin
                        cmd.cnt_load = 1'b1;
                        state_next   = ST_POST;
                    end
                    else
                    begin
                        cmd.run_end = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_POST:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = psi_pkg::EMIT_PAD_TRAIL;
                    cmd.cnt_dec   = 1'b1;
                    if (sts.cnt_one)
                    begin
                        cmd.run_end = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

### hdl/padding_segment_inserter_core.sv
// ----------------------------------------------------------------------------
// padding_segment_inserter_core: spreads padding segments through a contour
//
//   channel   dir   words                     payload
//   seg_in    in    one contour segment       seg_verb, point_count, p0..p3
//   seg_out   out   original or padding word  out_verb, q0..q3, is_padding,
//                                             run_end
//   cfg       in    register write            index, data
//
// Each segment gets reps leading padding words (reps = padding count divided
// by segment count plus one); a contour's last segment also gets reps
// trailing ones, and its first segment first waits for the split.
// Output words leave through the output register; the sequencer waits
// while that register is full and not taken.
// Reset clears the configuration to padding 0, segment count 1, and the
// contour state to its start. Register writes are always taken.
// ----------------------------------------------------------------------------
module padding_segment_inserter_core #(
    parameter int MAX_SEGMENTS = psi_pkg::MAX_SEGMENTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    psi_in_if.sink      seg_in,
    psi_out_if.source   seg_out,
    psi_cfg_if.sink     cfg
);

    localparam int NC = psi_pkg::NUM_COORDS;

    psi_pkg::cmd_t   cmd;
    psi_pkg::sts_t   sts;
    psi_pkg::coord_t in_pts  [NC];
    psi_pkg::coord_t out_pts [NC];
    logic            in_ready;

    // Gather the input points
    always_comb
    begin
        in_pts[0] = seg_in.p0_x;
        in_pts[1] = seg_in.p0_y;
        in_pts[2] = seg_in.p1_x;
        in_pts[3] = seg_in.p1_y;
        in_pts[4] = seg_in.p2_x;
        in_pts[5] = seg_in.p2_y;
        in_pts[6] = seg_in.p3_x;
        in_pts[7] = seg_in.p3_y;
    end

    assign seg_in.ready = in_ready;
    assign cfg.ready    = 1'b1;

    psi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (seg_in.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    psi_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .in_verb   (seg_in.seg_verb),
        .in_pcount (seg_in.point_count),
        .in_pts    (in_pts),
        .out_ready (seg_out.ready),
        .out_valid (seg_out.valid),
        .out_verb  (seg_out.out_verb),
        .out_pts   (out_pts),
        .out_pad   (seg_out.is_padding),
        .out_end   (seg_out.run_end),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Spread the output points
    assign seg_out.q0_x = out_pts[0];
    assign seg_out.q0_y = out_pts[1];
    assign seg_out.q1_x = out_pts[2];
    assign seg_out.q1_y = out_pts[3];
    assign seg_out.q2_x = out_pts[4];
    assign seg_out.q2_y = out_pts[5];
    assign seg_out.q3_x = out_pts[6];
    assign seg_out.q3_y = out_pts[7];

endmodule
